/* design/pairwise_distance_contact_map_unit_defines.svh */
// Assertion macros for the pairwise distance contact map unit.
// Define NO_ASSERTIONS to compile them out.
`ifndef PAIRWISE_DISTANCE_CONTACT_MAP_UNIT_DEFINES_SVH
`define PAIRWISE_DISTANCE_CONTACT_MAP_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PDCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdcm assertion failed");
`define PDCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdcm assertion failed");
`else
`define PDCM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PDCM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/pdcm_pkg.sv */
`timescale 1ns / 1ps

package pdcm_pkg;

	localparam int COORD_W = 24;
	localparam int DIFF_W = 25;
	localparam int DIST_W = 50;
	localparam int IDX_BITS = 6;
	localparam int MAX_POINTS_DEF = 64;
	localparam logic [DIST_W-1:0] CUTOFF_RESET = 50'd3211264;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

	typedef struct packed {
		logic                valid;
		logic                last;
		logic [IDX_BITS-1:0] earlier;
		logic [IDX_BITS-1:0] later;
	} pair_ctl_t;

endpackage

/* design/pairwise_distance_contact_map_unit.sv */
// The pairs of an accepted point pass the difference, square and sum/compare stages; they follow
// one per cycle while the output is not stalled. A stored point holds off new points (in_stall)
// for one full turn of the cell ring, which returns every stored point to its slot; a point
// dropped on a full store starts no turn. Output stalls freeze the ring and the distance pipeline together.
// Reset (arst_n low) empties the store and loads the cutoff with 49.0; the point slots
// themselves are not cleared.
`timescale 1ns / 1ps
`include "pairwise_distance_contact_map_unit_defines.svh"

module pairwise_distance_contact_map_unit #(
	parameter int MAX_POINTS = pdcm_pkg::MAX_POINTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   new_set,
	input  logic signed [pdcm_pkg::COORD_W-1:0]    pos_x,
	input  logic signed [pdcm_pkg::COORD_W-1:0]    pos_y,
	input  logic signed [pdcm_pkg::COORD_W-1:0]    pos_z,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic [pdcm_pkg::IDX_BITS-1:0]          earlier_index,
	output logic [pdcm_pkg::IDX_BITS-1:0]          later_index,
	output logic signed [pdcm_pkg::DIFF_W-1:0]     diff_x,
	output logic signed [pdcm_pkg::DIFF_W-1:0]     diff_y,
	output logic signed [pdcm_pkg::DIFF_W-1:0]     diff_z,
	output logic [pdcm_pkg::DIST_W-1:0]            dist_squared,
	output logic                                   in_contact,
	output logic                                   last_pair,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [pdcm_pkg::DIST_W-1:0]            cfg_data
);

	localparam int SW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);

	logic busy_q;
	logic [SW-1:0] step_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] n_q;
	logic [pdcm_pkg::DIST_W-1:0] cutoff_q;
	pdcm_pkg::point_t new_q;

	logic accept, take, en, shift;
	logic [CW-1:0] n_next;
	logic [CW-1:0] step_w;
	pdcm_pkg::pair_ctl_t issue_ctl, res_ctl;
	pdcm_pkg::point_t cell_q [MAX_POINTS];
	pdcm_pkg::point_t cell_d [MAX_POINTS];

	assign in_stall = busy_q;
	assign cfg_ready = 1'b1;
	assign accept = in_valid && !busy_q;
	assign n_next = new_set ? '0 : count_q;
	// Drop the item silently when the store is full.
	assign take = accept && (n_next < CW'(MAX_POINTS));
	assign en = !res_ctl.valid || !out_stall;
	assign shift = busy_q && en;
	assign step_w = CW'(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			count_q <= '0;
			n_q <= '0;
			cutoff_q <= pdcm_pkg::CUTOFF_RESET;
		end else begin
			if (cfg_valid) begin
				cutoff_q <= cfg_data;
			end
			if (take) begin
				busy_q <= 1'b1;
				step_q <= '0;
				n_q <= n_next;
				count_q <= n_next + CW'(1);
			end else if (shift) begin
				step_q <= step_q + SW'(1);
				if (step_q == SW'(MAX_POINTS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			new_q.x <= pos_x;
			new_q.y <= pos_y;
			new_q.z <= pos_z;
		end
	end

	// Ring of cells: the head holds stored index step_q; the slot passing the
	// head at step n_q is the free one and takes the new point on its way round.
	genvar gi;
	generate
		for (gi = 0; gi < MAX_POINTS; gi++) begin : g_cell
			if (gi == MAX_POINTS - 1) begin : g_tail
				assign cell_d[gi] = (step_w == n_q) ? new_q : cell_q[0];
			end else begin : g_mid
				assign cell_d[gi] = cell_q[gi + 1];
			end
			pdcm_cell u_cell (
				.clk  (clk),
				.shift(shift),
				.d    (cell_d[gi]),
				.q    (cell_q[gi])
			);
		end
	endgenerate

	always_comb begin
		issue_ctl.valid = busy_q && (step_w < n_q);
		issue_ctl.last = (step_w + CW'(1)) == n_q;
		issue_ctl.earlier = pdcm_pkg::IDX_BITS'(step_q);
		issue_ctl.later = pdcm_pkg::IDX_BITS'(n_q);
	end

	pdcm_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.earlier_pt(cell_q[0]),
		.later_pt  (new_q),
		.ctl       (issue_ctl),
		.cutoff    (cutoff_q),
		.ctl_out   (res_ctl),
		.dx        (diff_x),
		.dy        (diff_y),
		.dz        (diff_z),
		.dist_sq   (dist_squared),
		.contact   (in_contact)
	);

	assign out_valid = res_ctl.valid;
	assign earlier_index = res_ctl.earlier;
	assign later_index = res_ctl.later;
	assign last_pair = res_ctl.last;

	`PDCM_ASSERT_NXT(a_ring_turn, clk, arst_n, shift && step_q == SW'(MAX_POINTS - 1), !busy_q)
	`PDCM_ASSERT_NXT(a_new_set, clk, arst_n, in_valid && !in_stall && new_set, count_q == CW'(1))
	`PDCM_ASSERT_IMP(a_pair_order, clk, arst_n, out_valid, earlier_index < later_index)
	`PDCM_ASSERT_IMP(a_slot_free, clk, arst_n, busy_q, n_q < CW'(MAX_POINTS))

endmodule

/* design/pdcm_cell.sv */
`timescale 1ns / 1ps

// One slot of the point ring; takes its neighbor's point on every shift.
module pdcm_cell (
	input  logic             clk,
	input  logic             shift,
	input  pdcm_pkg::point_t d,
	output pdcm_pkg::point_t q
);

	pdcm_pkg::point_t point_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			point_q <= d;
		end
	end

	assign q = point_q;

endmodule

/* design/pdcm_dist.sv */
`timescale 1ns / 1ps

// Difference, square, sum and cutoff compare in three stages.
module pdcm_dist (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  pdcm_pkg::point_t               earlier_pt,
	input  pdcm_pkg::point_t               later_pt,
	input  pdcm_pkg::pair_ctl_t            ctl,
	input  logic [pdcm_pkg::DIST_W-1:0]    cutoff,
	output pdcm_pkg::pair_ctl_t            ctl_out,
	output logic signed [pdcm_pkg::DIFF_W-1:0] dx,
	output logic signed [pdcm_pkg::DIFF_W-1:0] dy,
	output logic signed [pdcm_pkg::DIFF_W-1:0] dz,
	output logic [pdcm_pkg::DIST_W-1:0]    dist_sq,
	output logic                           contact
);

	pdcm_pkg::pair_ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic signed [pdcm_pkg::DIFF_W-1:0] dx_s1, dy_s1, dz_s1;
	logic signed [pdcm_pkg::DIFF_W-1:0] dx_s2, dy_s2, dz_s2;
	logic signed [pdcm_pkg::DIFF_W-1:0] dx_s3, dy_s3, dz_s3;
	logic signed [pdcm_pkg::DIST_W-1:0] sqx_s2, sqy_s2, sqz_s2;
	logic [pdcm_pkg::DIST_W-1:0] sum_c;
	logic [pdcm_pkg::DIST_W-1:0] dist_s3;
	logic contact_s3;

	// Squares are never negative, so their bits read directly as unsigned.
	assign sum_c = $unsigned(sqx_s2) + $unsigned(sqy_s2) + $unsigned(sqz_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= pdcm_pkg::DIFF_W'(earlier_pt.x) - pdcm_pkg::DIFF_W'(later_pt.x);
			dy_s1 <= pdcm_pkg::DIFF_W'(earlier_pt.y) - pdcm_pkg::DIFF_W'(later_pt.y);
			dz_s1 <= pdcm_pkg::DIFF_W'(earlier_pt.z) - pdcm_pkg::DIFF_W'(later_pt.z);
			sqx_s2 <= dx_s1 * dx_s1;
			sqy_s2 <= dy_s1 * dy_s1;
			sqz_s2 <= dz_s1 * dz_s1;
			dx_s2 <= dx_s1;
			dy_s2 <= dy_s1;
			dz_s2 <= dz_s1;
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			dz_s3 <= dz_s2;
			dist_s3 <= sum_c;
			contact_s3 <= (sum_c <= cutoff);
		end
	end

	assign ctl_out = ctl_s3;
	assign dx = dx_s3;
	assign dy = dy_s3;
	assign dz = dz_s3;
	assign dist_sq = dist_s3;
	assign contact = contact_s3;

endmodule
